>>> rtl/core/mnd_pkg.sv
// Package for the MIDI NRPN decoder: controller numbers, message type code,
// stream widths and the layout of one channel's parameter entry.
// No dependencies.
package mnd_pkg;

    localparam int CHANNELS_DEFAULT = 16;

    localparam logic [3:0] MSG_CONTROL_CHANGE = 4'hB;

    localparam logic [6:0] CC_DATA_HIGH = 7'd6;
    localparam logic [6:0] CC_DATA_LOW  = 7'd38;
    localparam logic [6:0] CC_NRPN_HIGH = 7'd99;
    localparam logic [6:0] CC_NRPN_LOW  = 7'd98;

    localparam logic [6:0] HALF_MAX = 7'd127;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    typedef struct packed {
        logic [6:0] param_high;
        logic [6:0] param_low;
        logic [6:0] value_high;
        logic [6:0] value_low;
    } entry_t;

endpackage

>>> rtl/core/midi_nrpn_decoder.sv
// A request is first captured in the input register; its result is then loaded into the result register.
// Throughput: one request per cycle while no result waits on m_tready; the per-channel table is read,
// updated and written back between the input register and the result register.
// Reset (aresetn low, synchronous) empties both registers and clears every channel entry.
// A result waiting on m_tready stalls the input register and the table update.
// Depends on mnd_pkg.
module midi_nrpn_decoder
    import mnd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] status_byte, [14:8] data_first, [21:15] data_second, [23:22] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [3:0] channel_out, [17:4] param_number, [31:18] param_value
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] is_nrpn
    output logic                 m_tuser
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic       in_valid_reg;
    logic [7:0] status_reg;
    logic [6:0] ctrl_reg;
    logic [6:0] val_reg;

    logic        out_valid_reg;
    logic        is_nrpn_reg;
    logic [3:0]  chan_out_reg;
    logic [13:0] number_reg;
    logic [13:0] value_reg;

    entry_t table_reg [CHANNELS];

    logic             advance;
    logic             chan_ok;
    logic             is_cc;
    logic [3:0]       chan;
    logic [IDX_W-1:0] idx;
    entry_t           entry_old;
    entry_t           entry_next;
    logic             write_en;
    logic             emit;
    logic             nrpn;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign chan    = status_reg[3:0];
    assign is_cc   = (status_reg[7:4] == MSG_CONTROL_CHANGE);
    assign chan_ok = ({1'b0, chan} < 5'(CHANNELS));
    assign idx     = chan_ok ? chan[IDX_W-1:0] : '0;
    assign entry_old = table_reg[idx];

    always_comb begin
        entry_next = entry_old;
        write_en   = 1'b0;
        nrpn       = 1'b0;
        case (ctrl_reg)
            CC_NRPN_HIGH: begin
                entry_next.param_high = val_reg;
                entry_next.param_low  = '0;
                write_en = 1'b1;
            end
            CC_NRPN_LOW: begin
                entry_next.param_low = val_reg;
                write_en = 1'b1;
            end
            CC_DATA_HIGH: begin
                if (val_reg < entry_old.value_high) begin
                    entry_next.value_low = HALF_MAX;
                end else if (val_reg > entry_old.value_high) begin
                    entry_next.value_low = '0;
                end
                entry_next.value_high = val_reg;
                write_en = 1'b1;
                nrpn     = 1'b1;
            end
            CC_DATA_LOW: begin
                entry_next.value_low = val_reg;
                write_en = 1'b1;
                nrpn     = 1'b1;
            end
            default: begin
                nrpn = 1'b0;
            end
        endcase
        emit = is_cc && chan_ok &&
               !((ctrl_reg == CC_NRPN_HIGH) || (ctrl_reg == CC_NRPN_LOW));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            status_reg <= s_tdata[7:0];
            ctrl_reg   <= s_tdata[14:8];
            val_reg    <= s_tdata[21:15];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                table_reg[i] <= '0;
            end
        end else if (advance && is_cc && chan_ok && write_en) begin
            table_reg[idx] <= entry_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            is_nrpn_reg  <= nrpn;
            chan_out_reg <= chan;
            if (nrpn) begin
                number_reg <= {entry_next.param_high, entry_next.param_low};
                value_reg  <= {entry_next.value_high, entry_next.value_low};
            end else begin
                number_reg <= {7'd0, ctrl_reg};
                value_reg  <= {7'd0, val_reg};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {value_reg, number_reg, chan_out_reg};
    assign m_tuser  = is_nrpn_reg;

endmodule

>>> rtl/core/mnd_checker.sv
// Port-level checker for the MIDI NRPN decoder, attached to the top level by bind.
// Depends on mnd_pkg and midi_nrpn_decoder.
module mnd_checker
    import mnd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // A plain controller result carries only 7-bit number and value.
    a_plain_narrow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[17:11] == 7'd0) && (m_tdata[31:25] == 7'd0))
        else $error("plain controller result wider than seven bits");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not empty after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // With the output idle the input side can never be held off.
    a_ready_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && $past(!m_tvalid) && $past(aresetn)) |-> s_tready)
        else $error("request refused while the block is idle");

endmodule

bind midi_nrpn_decoder mnd_checker u_mnd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
